@@ rtl/core/bsa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bsa_pkg;

  // Field widths
  localparam int IDX_W = 10;  // slot_index
  localparam int CNT_W = 11;  // num_bits, result_index
  localparam int APB_W = 32;

  // Default geometry
  localparam int NBITS_DEF     = 1024;
  localparam int WORD_BITS_DEF = 64;

  localparam logic [CNT_W-1:0] NUM_BITS_RST = 11'd1024;

  // Register select (paddr[2])
  localparam logic REG_NUM_BITS = 1'b0;

  // Request codes
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_FIND  = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_OOR  = 2'd2;

  // Token that walks the row of cells, one cell per cycle while the row advances
  typedef struct packed {
    logic             vld;
    logic [1:0]       op;
    logic [CNT_W-1:0] lo;      // search start, or free target
    logic [CNT_W-1:0] hi;      // search limit (active bit count)
    logic             clr;     // free target is in range
    logic             done;    // search already satisfied upstream
    logic [1:0]       status;
    logic [CNT_W-1:0] res;
  } tok_t;

endpackage

`default_nettype wire

@@ rtl/core/bsa_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bsa_cell #(
  parameter int WORD_BITS = bsa_pkg::WORD_BITS_DEF,
  parameter int CELL_IDX  = 0
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         adv,
  input  wire bsa_pkg::tok_t tin,
  output bsa_pkg::tok_t     tout
);

  localparam int          BW   = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int          CW   = bsa_pkg::CNT_W;
  localparam logic [31:0] BASE = 32'(CELL_IDX * WORD_BITS);
  localparam logic [31:0] TOP  = 32'((CELL_IDX + 1) * WORD_BITS);
  localparam logic [WORD_BITS-1:0] ONE = {{(WORD_BITS-1){1'b0}}, 1'b1};

  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] word_next;
  logic [WORD_BITS-1:0] lo_mask, hi_mask, avail, low, clr_bit;
  logic [31:0]          lo32, hi32, lo_diff, hi_diff, res32;
  logic [BW-1:0]        enc;
  logic                 search;
  bsa_pkg::tok_t        tnext;

  always_comb begin
    lo32    = {{(32-CW){1'b0}}, tin.lo};
    hi32    = {{(32-CW){1'b0}}, tin.hi};
    lo_diff = lo32 - BASE;
    hi_diff = hi32 - BASE;

    // window of this word that lies in [lo, hi)
    if (lo32 <= BASE) begin
      lo_mask = '1;
    end else if (lo32 >= TOP) begin
      lo_mask = '0;
    end else begin
      lo_mask = {WORD_BITS{1'b1}} << lo_diff[BW-1:0];
    end
    if (hi32 >= TOP) begin
      hi_mask = '1;
    end else if (hi32 <= BASE) begin
      hi_mask = '0;
    end else begin
      hi_mask = ~({WORD_BITS{1'b1}} << hi_diff[BW-1:0]);
    end

    search = tin.vld && !tin.done &&
             (tin.op == bsa_pkg::REQ_ALLOC || tin.op == bsa_pkg::REQ_FIND);
    avail  = ~word & lo_mask & hi_mask;
    // isolate lowest clear bit, then encode it
    low    = avail & (~avail + ONE);
    enc    = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (low[b]) begin
        enc = enc | BW'(b);
      end
    end
    res32 = BASE + {{(32-BW){1'b0}}, enc};

    if (tin.vld && tin.op == bsa_pkg::REQ_FREE && tin.clr &&
        lo32 >= BASE && lo32 < TOP) begin
      clr_bit = ONE << lo_diff[BW-1:0];
    end else begin
      clr_bit = '0;
    end

    tnext     = tin;
    word_next = word & ~clr_bit;
    if (search && avail != '0) begin
      tnext.done   = 1'b1;
      tnext.status = bsa_pkg::ST_OK;
      tnext.res    = res32[CW-1:0];
      if (tin.op == bsa_pkg::REQ_ALLOC) begin
        word_next = word_next | low;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word <= '0;
      tout <= '0;
    end else if (adv) begin
      word <= word_next;
      tout <= tnext;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bitmap_slot_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Bitmap slot allocator: NBITS slots, held as a row of cells that each own
// one WORD_BITS-wide word of the map.
// Request channel (in_valid / in_stall, req_type, slot_index): allocate the
// lowest clear slot, free one slot, or find the next clear slot at or above
// slot_index. Result channel (out_valid / out_stall, status, result_index):
// exactly one beat per request, in request order.
// A request becomes a token that walks the row, one cell per cycle while
// the row advances; each cell searches, sets or clears bits of its own word
// as the token passes. The token goes from the entry slot through the
// cells to the output register. One request is in flight at a time, so a
// new request is not taken until the last has retired into the output
// register. A finished result sits in the output register while the next
// request is taken. While out_stall holds a result, the whole row freezes
// until the result beat leaves.
// Reset clears the map (each cell word resets) and sets num_bits to 1024.
// num_bits is written over the APB port at offset 0 and must only change
// while no request is in flight.

module bitmap_slot_allocator #(
  parameter int NBITS     = bsa_pkg::NBITS_DEF,
  parameter int WORD_BITS = bsa_pkg::WORD_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // request channel
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                req_type,
  input  wire logic [bsa_pkg::IDX_W-1:0] slot_index,
  // result channel
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [1:0]                     status,
  output logic [bsa_pkg::CNT_W-1:0]      result_index,
  // configuration
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [bsa_pkg::APB_W-1:0] pwdata,
  output logic [bsa_pkg::APB_W-1:0]      prdata,
  output logic                           pready
);

  localparam int CW     = bsa_pkg::CNT_W;
  localparam int NWORDS = (NBITS + WORD_BITS - 1) / WORD_BITS;
  // largest active count that num_bits can select
  localparam logic [CW-1:0] NCAP =
    (NBITS >= (1 << CW)) ? {CW{1'b1}} : CW'(NBITS);

  logic [CW-1:0] num_bits;
  logic [CW-1:0] n_act;
  logic          cfg_wr;
  logic          busy;
  logic          acc;
  logic          adv;
  logic [CW-1:0] idx_ext;

  bsa_pkg::tok_t tok_in;
  bsa_pkg::tok_t tok_new;
  bsa_pkg::tok_t link [NWORDS+1];
  logic [NWORDS:0] chain_vld;

  // APB: always ready, one register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == bsa_pkg::REG_NUM_BITS);
  assign prdata = (paddr[2] == bsa_pkg::REG_NUM_BITS) ?
                  {{(bsa_pkg::APB_W-CW){1'b0}}, num_bits} : '0;

  // saturate the bit count to the map size
  assign n_act = (num_bits > NCAP) ? NCAP : num_bits;

  assign in_stall = busy;
  assign acc      = in_valid && !in_stall;
  // the row moves unless a result is held by the receiver
  assign adv      = !out_valid || !out_stall;
  assign idx_ext  = {1'b0, slot_index};

  // build the token for a new request
  always_comb begin
    tok_new     = '0;
    tok_new.vld = 1'b1;
    tok_new.hi  = n_act;
    case (req_type)
      bsa_pkg::REQ_ALLOC: begin
        tok_new.op     = bsa_pkg::REQ_ALLOC;
        tok_new.lo     = '0;
        tok_new.status = bsa_pkg::ST_NONE;
        tok_new.res    = n_act;
      end
      bsa_pkg::REQ_FREE: begin
        tok_new.op     = bsa_pkg::REQ_FREE;
        tok_new.lo     = idx_ext;
        tok_new.clr    = idx_ext < n_act;
        tok_new.status = (idx_ext < n_act) ? bsa_pkg::ST_OK : bsa_pkg::ST_OOR;
        tok_new.res    = idx_ext;
      end
      bsa_pkg::REQ_FIND: begin
        // an offset at or past the count leaves an empty window: not found
        tok_new.op     = bsa_pkg::REQ_FIND;
        tok_new.lo     = idx_ext;
        tok_new.status = bsa_pkg::ST_NONE;
        tok_new.res    = n_act;
      end
      default: begin
        // unknown request: pass through untouched
        tok_new.op     = bsa_pkg::REQ_NONE;
        tok_new.hi     = '0;
        tok_new.status = bsa_pkg::ST_OOR;
        tok_new.res    = '0;
      end
    endcase
  end

  // row of cells, one map word each
  assign link[0] = tok_in;

  for (genvar k = 0; k < NWORDS; k++) begin : g_cell
    bsa_cell #(
      .WORD_BITS (WORD_BITS),
      .CELL_IDX  (k)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .tin  (link[k]),
      .tout (link[k+1])
    );
  end

  always_comb begin
    for (int k = 0; k <= NWORDS; k++) begin
      chain_vld[k] = link[k].vld;
    end
  end

  // control: config register, entry slot, busy flag, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      num_bits  <= bsa_pkg::NUM_BITS_RST;
      tok_in    <= '0;
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        num_bits <= pwdata[CW-1:0];
      end
      // hold the new token until the first cell takes it
      if (acc) begin
        tok_in <= tok_new;
        busy   <= 1'b1;
      end else if (adv) begin
        tok_in.vld <= 1'b0;
      end
      // retire the token from the end of the row into the output register
      if (adv && link[NWORDS].vld) begin
        out_valid <= 1'b1;
        busy      <= 1'b0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (adv && link[NWORDS].vld) begin
      status       <= link[NWORDS].status;
      result_index <= link[NWORDS].res;
    end
  end

  // never more than one token in the row
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(chain_vld) <= 1)
    else $error("more than one token in the cell row");

  // busy exactly while a token is in flight
  a_busy_tracks: assert property (@(posedge clk) disable iff (rst)
    busy == (|chain_vld))
    else $error("busy flag out of step with the cell row");

  // an accepted request lands in the entry slot
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    acc |=> tok_in.vld)
    else $error("accepted request did not enter the row");

endmodule

`default_nettype wire
